FILE: hdl/cbvh_pkg.sv
// Shared types, constants and the microcode program for the volumetric head block.
// Depends on nothing; the sequencer, datapath, top level and bench refer to it by scoped names.
`default_nettype none

package cbvh_pkg;

    localparam int unsigned ITERATIONS = 32;
    localparam int unsigned CNT_W      = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned LIMB_W     = 32;
    localparam int unsigned OPND_W     = 37;
    localparam int unsigned PROD_W     = 2 * OPND_W;
    localparam int unsigned ACC_W      = 140;
    localparam int unsigned T_W        = 128;
    localparam int unsigned U_W        = 68;
    localparam int unsigned PC_W       = 4;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [PC_W-1:0]   t_pc;

    typedef enum logic [3:0] {
        SRC_X, SRC_M, SRC_D, SRC_A, SRC_K,
        SRC_T0, SRC_T1, SRC_T2, SRC_U0, SRC_U1
    } t_src;

    typedef enum logic [1:0] {BASE_ZERO, BASE_ACC, BASE_B, BASE_NEGC} t_base;

    typedef enum logic [2:0] {WR_NONE, WR_T, WR_U, WR_B, WR_C} t_wr;

    typedef enum logic [1:0] {SEQ_NEXT, SEQ_IDLE, SEQ_EVAL, SEQ_OUT} t_seq;

    typedef struct packed {
        t_seq       seq;
        logic       mac;
        t_src       src_a;
        t_src       src_b;
        logic [1:0] shift;   // addend shift in limbs
        t_base      base;
        t_wr        wr;
        t_pc        target;
    } t_uword;

    typedef struct packed {
        logic in_take;
        logic linear;
        logic stop;
        logic out_load;
    } t_status;

    localparam t_pc P_IDLE = t_pc'(0);
    localparam t_pc P_LOOP = t_pc'(8);
    localparam t_pc P_OUT  = t_pc'(15);

    localparam t_uword UW_NOP = '{seq: SEQ_NEXT, mac: 1'b0, src_a: SRC_X, src_b: SRC_X,
                                  shift: 2'd0, base: BASE_ACC, wr: WR_NONE, target: P_IDLE};

    function automatic t_uword uw_mac(input t_src a, input t_src b, input logic [1:0] sh,
                                      input t_base base, input t_wr wr);
        t_uword w;
        w       = UW_NOP;
        w.mac   = 1'b1;
        w.src_a = a;
        w.src_b = b;
        w.shift = sh;
        w.base  = base;
        w.wr    = wr;
        return w;
    endfunction

    function automatic t_uword uw_seq(input t_seq seq, input t_pc target);
        t_uword w;
        w        = UW_NOP;
        w.seq    = seq;
        w.target = target;
        return w;
    endfunction

    // R(x) = x^2 * (A*x + B) - C, A = 2e - m, B = m*(2m - 3e), C = d*m^3
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            t_pc'(0):  w = uw_seq(SEQ_IDLE, P_OUT);
            t_pc'(1):  w = uw_mac(SRC_M,  SRC_M,  2'd0, BASE_ZERO, WR_T);   // m^2
            t_pc'(2):  w = uw_mac(SRC_T0, SRC_M,  2'd0, BASE_ZERO, WR_NONE);
            t_pc'(3):  w = uw_mac(SRC_T1, SRC_M,  2'd1, BASE_ACC,  WR_T);   // m^3
            t_pc'(4):  w = uw_mac(SRC_T0, SRC_D,  2'd0, BASE_ZERO, WR_NONE);
            t_pc'(5):  w = uw_mac(SRC_T1, SRC_D,  2'd1, BASE_ACC,  WR_NONE);
            t_pc'(6):  w = uw_mac(SRC_T2, SRC_D,  2'd2, BASE_ACC,  WR_C);   // d*m^3
            t_pc'(7):  w = uw_mac(SRC_K,  SRC_M,  2'd0, BASE_ZERO, WR_B);
            t_pc'(8):  w = uw_mac(SRC_X,  SRC_X,  2'd0, BASE_ZERO, WR_T);   // x^2
            t_pc'(9):  w = uw_mac(SRC_A,  SRC_X,  2'd0, BASE_B,    WR_U);   // A*x + B
            t_pc'(10): w = uw_mac(SRC_T0, SRC_U0, 2'd0, BASE_NEGC, WR_NONE);
            t_pc'(11): w = uw_mac(SRC_T0, SRC_U1, 2'd1, BASE_ACC,  WR_NONE);
            t_pc'(12): w = uw_mac(SRC_T1, SRC_U0, 2'd1, BASE_ACC,  WR_NONE);
            t_pc'(13): w = uw_mac(SRC_T1, SRC_U1, 2'd2, BASE_ACC,  WR_NONE);
            t_pc'(14): w = uw_seq(SEQ_EVAL, P_LOOP);
            t_pc'(15): w = uw_seq(SEQ_OUT, P_IDLE);
            default:   w = UW_NOP;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cbvh_in_if.sv
// Input channel: valid/ready handshake with the three depth fields.
// Depends on nothing.
`default_nettype none

interface cbvh_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pond_depth;
    logic [31:0] depression_max;
    logic [31:0] excluded_depth;

    modport source (output valid, output pond_depth, output depression_max,
                    output excluded_depth, input ready);
    modport sink   (input valid, input pond_depth, input depression_max,
                    input excluded_depth, output ready);
endinterface

`default_nettype wire

FILE: hdl/cbvh_out_if.sv
// Output channel: valid/ready handshake with the head and the linear flag.
// Depends on nothing.
`default_nettype none

interface cbvh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] volumetric_head;
    logic        linear_branch;

    modport source (output valid, output volumetric_head, output linear_branch,
                    input ready);
    modport sink   (input valid, input volumetric_head, input linear_branch,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/cbvh_sequencer.sv
// Step counter and microcode table lookup with conditional jumps.
// Depends on cbvh_pkg.
`default_nettype none

module cbvh_sequencer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cbvh_pkg::t_status i_st,
    output cbvh_pkg::t_uword      o_uw
);

    cbvh_pkg::t_pc    r_pc;
    cbvh_pkg::t_pc    n_pc;
    cbvh_pkg::t_pc    w_pc_inc;
    cbvh_pkg::t_uword w_uw;

    assign w_uw     = cbvh_pkg::ucode(r_pc);
    assign w_pc_inc = r_pc + cbvh_pkg::t_pc'(1);
    assign o_uw     = w_uw;

    always_comb begin
        n_pc = r_pc;
        unique case (w_uw.seq)
            cbvh_pkg::SEQ_NEXT: n_pc = w_pc_inc;
            cbvh_pkg::SEQ_IDLE: begin
                if (i_st.in_take) begin
                    n_pc = i_st.linear ? w_uw.target : w_pc_inc;
                end
            end
            cbvh_pkg::SEQ_EVAL: n_pc = i_st.stop ? w_pc_inc : w_uw.target;
            cbvh_pkg::SEQ_OUT:  n_pc = i_st.out_load ? w_uw.target : r_pc;
            default:            n_pc = cbvh_pkg::P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cbvh_pkg::P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cbvh_datapath.sv
// Shared multiplier, wide accumulator, operand registers, bisection bounds and
// output register. Depends on cbvh_pkg, cbvh_in_if and cbvh_out_if.
`default_nettype none

module cbvh_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cbvh_pkg::t_uword  i_uw,
    cbvh_in_if.sink                i_req,
    cbvh_out_if.source             o_rsp,
    output cbvh_pkg::t_status      o_st
);

    localparam int unsigned OW = cbvh_pkg::OPND_W;
    localparam int unsigned DW = cbvh_pkg::DATA_W;
    localparam int unsigned LW = cbvh_pkg::LIMB_W;
    localparam int unsigned UW = cbvh_pkg::U_W;
    localparam int unsigned TW = cbvh_pkg::T_W;
    localparam int unsigned AW = cbvh_pkg::ACC_W;
    localparam int unsigned PW = cbvh_pkg::PROD_W;

    cbvh_pkg::t_data          r_d, r_m, r_x, r_lo, r_hi, r_res;
    logic signed [OW-1:0]     r_a, r_k;
    logic [TW-1:0]            r_t, r_c;
    logic [UW-1:0]            r_u, r_b;
    logic signed [AW-1:0]     r_acc;
    logic [cbvh_pkg::CNT_W-1:0] r_cnt;
    logic                     r_s1_neg, r_s1_pos, r_lin;
    logic                     r_ov;
    cbvh_pkg::t_data          r_out_head;
    logic                     r_out_lin;

    logic signed [OW-1:0]     w_opa, w_opb;
    logic signed [PW-1:0]     w_prod;
    logic signed [AW-1:0]     w_ext, w_add, w_base, w_acc_next;
    logic                     w_take, w_linear, w_eval, w_stop, w_opp, w_out_load;
    logic                     w_s3_neg, w_s3_pos, w_s3_zero, w_last;
    logic [DW:0]              w_sum, w_mid_l, w_mid_h;
    logic [OW-1:0]            w_a_in, w_k_in;

    function automatic logic signed [OW-1:0] pick(
        input cbvh_pkg::t_src s, input cbvh_pkg::t_data x, input cbvh_pkg::t_data m,
        input cbvh_pkg::t_data d, input logic signed [OW-1:0] a,
        input logic signed [OW-1:0] k, input logic [TW-1:0] t, input logic [UW-1:0] u);
        logic signed [OW-1:0] v;
        v = '0;
        unique case (s)
            cbvh_pkg::SRC_X:  v = {{(OW-DW){1'b0}}, x};
            cbvh_pkg::SRC_M:  v = {{(OW-DW){1'b0}}, m};
            cbvh_pkg::SRC_D:  v = {{(OW-DW){1'b0}}, d};
            cbvh_pkg::SRC_A:  v = a;
            cbvh_pkg::SRC_K:  v = k;
            cbvh_pkg::SRC_T0: v = {{(OW-LW){1'b0}}, t[LW-1:0]};
            cbvh_pkg::SRC_T1: v = {{(OW-LW){1'b0}}, t[2*LW-1:LW]};
            cbvh_pkg::SRC_T2: v = {{(OW-LW){1'b0}}, t[3*LW-1:2*LW]};
            cbvh_pkg::SRC_U0: v = {{(OW-LW){1'b0}}, u[LW-1:0]};
            cbvh_pkg::SRC_U1: v = {{(OW-(UW-LW)){u[UW-1]}}, u[UW-1:LW]};
            default:          v = '0;
        endcase
        return v;
    endfunction

    assign w_opa  = pick(i_uw.src_a, r_x, r_m, r_d, r_a, r_k, r_t, r_u);
    assign w_opb  = pick(i_uw.src_b, r_x, r_m, r_d, r_a, r_k, r_t, r_u);
    assign w_prod = w_opa * w_opb;
    assign w_ext  = {{(AW-PW){w_prod[PW-1]}}, w_prod};

    always_comb begin
        w_add = w_ext;
        unique case (i_uw.shift)
            2'd0:    w_add = w_ext;
            2'd1:    w_add = w_ext <<< LW;
            2'd2:    w_add = w_ext <<< (2 * LW);
            default: w_add = w_ext;
        endcase
    end

    always_comb begin
        w_base = '0;
        unique case (i_uw.base)
            cbvh_pkg::BASE_ZERO: w_base = '0;
            cbvh_pkg::BASE_ACC:  w_base = r_acc;
            cbvh_pkg::BASE_B:    w_base = {{(AW-UW){r_b[UW-1]}}, r_b};
            cbvh_pkg::BASE_NEGC: w_base = AW'(0) - {{(AW-TW){1'b0}}, r_c};
            default:             w_base = '0;
        endcase
    end

    assign w_acc_next = w_base + w_add;

    // handshake and branch conditions
    assign i_req.ready = (i_uw.seq == cbvh_pkg::SEQ_IDLE);
    assign w_take      = i_req.valid && i_req.ready;
    assign w_linear    = i_req.pond_depth > i_req.depression_max;
    assign w_sum       = {1'b0, i_req.pond_depth} + {1'b0, i_req.excluded_depth};
    assign w_a_in      = {{(OW-DW-1){1'b0}}, i_req.excluded_depth, 1'b0}
                       - {{(OW-DW){1'b0}}, i_req.depression_max};
    assign w_k_in      = {{(OW-DW-1){1'b0}}, i_req.depression_max, 1'b0}
                       - {{(OW-DW-1){1'b0}}, i_req.excluded_depth, 1'b0}
                       - {{(OW-DW){1'b0}}, i_req.excluded_depth};

    // sign of the residual at the midpoint, stop test and next midpoints
    assign w_eval    = (i_uw.seq == cbvh_pkg::SEQ_EVAL);
    assign w_s3_zero = (r_acc == '0);
    assign w_s3_neg  = r_acc[AW-1];
    assign w_s3_pos  = !w_s3_neg && !w_s3_zero;
    assign w_opp     = (r_s1_neg && w_s3_pos) || (r_s1_pos && w_s3_neg);
    assign w_last    = (r_cnt == cbvh_pkg::CNT_W'(cbvh_pkg::ITERATIONS - 1));
    assign w_stop    = w_s3_zero || w_last;
    assign w_mid_l   = {1'b0, r_lo} + {1'b0, r_x};
    assign w_mid_h   = {1'b0, r_x} + {1'b0, r_hi};

    assign w_out_load = (i_uw.seq == cbvh_pkg::SEQ_OUT) && (!r_ov || o_rsp.ready);

    assign o_st = '{in_take: w_take, linear: w_linear, stop: w_stop, out_load: w_out_load};

    assign o_rsp.valid           = r_ov;
    assign o_rsp.volumetric_head = r_out_head;
    assign o_rsp.linear_branch   = r_out_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_load) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_head <= r_res;
            r_out_lin  <= r_lin;
        end
        if (i_uw.mac) begin
            r_acc <= w_acc_next;
        end
        unique case (i_uw.wr)
            cbvh_pkg::WR_NONE: ;
            cbvh_pkg::WR_T:    r_t <= w_acc_next[TW-1:0];
            cbvh_pkg::WR_U:    r_u <= w_acc_next[UW-1:0];
            cbvh_pkg::WR_B:    r_b <= w_acc_next[UW-1:0];
            cbvh_pkg::WR_C:    r_c <= w_acc_next[TW-1:0];
            default: ;
        endcase
        if (w_take) begin
            r_d      <= i_req.pond_depth;
            r_m      <= i_req.depression_max;
            r_a      <= w_a_in;
            r_k      <= w_k_in;
            r_lo     <= '0;
            r_hi     <= i_req.depression_max;
            r_x      <= i_req.depression_max >> 1;
            r_cnt    <= '0;
            r_s1_neg <= (i_req.pond_depth != '0);
            r_s1_pos <= 1'b0;
            r_lin    <= w_linear;
            r_res    <= w_sum[DW] ? '1 : w_sum[DW-1:0];
        end else if (w_eval) begin
            if (w_stop) begin
                r_res <= r_x;
            end else if (w_opp) begin
                r_hi  <= r_x;
                r_x   <= w_mid_l[DW:1];
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_lo     <= r_x;
                r_x      <= w_mid_h[DW:1];
                r_s1_neg <= w_s3_neg;
                r_s1_pos <= w_s3_pos;
                r_cnt    <= r_cnt + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cubic_bisection_volumetric_head.sv
// Top level of the volumetric head block: microcode sequencer plus datapath.
// Depends on cbvh_pkg, cbvh_in_if, cbvh_out_if, cbvh_sequencer, cbvh_datapath.
//
//   port    | dir | handshake   | item contents
//   i_req   | in  | valid/ready | pond_depth, depression_max, excluded_depth
//   o_rsp   | out | valid/ready | volumetric_head, linear_branch
//
// Linear items go from acceptance straight to the output step; bisection items run
// the setup steps, then the residual steps and one evaluation per halving, for at most
// ITERATIONS evaluations, on the one 37x37 multiplier that forms a single partial product of the residual per step.
// Reset returns the step counter to idle and empties the output register.
// The final step holds while the output register is full and not being taken.
`default_nettype none

module cubic_bisection_volumetric_head (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cbvh_in_if.sink     i_req,
    cbvh_out_if.source  o_rsp
);

    cbvh_pkg::t_uword  w_uw;
    cbvh_pkg::t_status w_st;

    cbvh_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_uw    (w_uw)
    );

    cbvh_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uw    (w_uw),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_st    (w_st)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for cubic_bisection_volumetric_head: drives depth items, predicts
// the head by bisecting the scaled cubic and checks each result item in order.
// Depends on cbvh_pkg, cbvh_in_if, cbvh_out_if and the block's RTL.

module tb;

    typedef struct {
        cbvh_pkg::t_data ponded;
        cbvh_pkg::t_data dmax;
        cbvh_pkg::t_data excl;
        bit              drain;
    } t_depth_item;

    typedef struct {
        cbvh_pkg::t_data head;
        logic            lin;
    } t_head;

    typedef enum logic [1:0] {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    localparam int unsigned N_RANDOM    = 1500;
    localparam int unsigned LONG_HOLD   = 800;
    localparam int unsigned SETTLE_CYCS = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbvh_in_if  req_if ();
    cbvh_out_if rsp_if ();

    cubic_bisection_volumetric_head DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_depth_item pend_q[$];
    t_head       head_due_q[$];
    t_depth_item cur_item;
    int unsigned err_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sign of (2e - m)x^3 + (2m - 3e)m x^2 - d m^3, split into positive and negative sums
    function automatic int scaled_residual_sign(cbvh_pkg::t_data x, cbvh_pkg::t_data d,
                                                cbvh_pkg::t_data m, cbvh_pkg::t_data e);
        logic [191:0] wx, wd, wm, we, x2, x3, pos, neg;
        wx  = x;
        wd  = d;
        wm  = m;
        we  = e;
        x2  = wx * wx;
        x3  = x2 * wx;
        pos = 2 * we * x3 + 2 * wm * wm * x2;
        neg = wm * x3 + 3 * we * wm * x2 + wd * wm * wm * wm;
        if (pos > neg)
            return 1;
        else if (pos < neg)
            return -1;
        return 0;
    endfunction

    function automatic t_head volumetric_head_of(t_depth_item it);
        t_head           r;
        logic [32:0]     sum;
        cbvh_pkg::t_data lo, hi, mid;
        int              s_lo, s_mid;
        if (it.ponded > it.dmax) begin
            sum   = {1'b0, it.ponded} + {1'b0, it.excl};
            r.head = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r.lin  = 1'b1;
            return r;
        end
        lo  = '0;
        hi  = it.dmax;
        mid = '0;
        for (int k = 0; k < cbvh_pkg::ITERATIONS; k++) begin
            sum   = ({1'b0, lo} + {1'b0, hi}) >> 1;
            mid   = sum[31:0];
            s_lo  = scaled_residual_sign(lo, it.ponded, it.dmax, it.excl);
            s_mid = scaled_residual_sign(mid, it.ponded, it.dmax, it.excl);
            if (s_lo * s_mid < 0)
                hi = mid;
            else
                lo = mid;
            if (s_mid == 0)
                break;
        end
        r.head = mid;
        r.lin  = 1'b0;
        return r;
    endfunction

    function automatic void add_item(cbvh_pkg::t_data d, cbvh_pkg::t_data m,
                                     cbvh_pkg::t_data e, bit drain);
        t_depth_item it;
        it.ponded = d;
        it.dmax   = m;
        it.excl   = e;
        it.drain  = drain;
        pend_q.insert(pend_q.size(), it);
    endfunction

    function automatic t_depth_item random_depth_item();
        t_depth_item it;
        int unsigned kind;
        kind     = $urandom_range(9, 0);
        it.drain = 1'b0;
        it.excl  = $urandom;
        if (kind <= 2) begin
            // linear branch, half of them near the saturation edge
            it.dmax   = $urandom_range(32'hFFFF_FFFE, 0);
            it.ponded = $urandom_range(32'hFFFF_FFFF, it.dmax + 1);
            if ($urandom_range(1, 0) == 0)
                it.excl = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFFF - it.ponded);
        end else if (kind <= 4) begin
            // small sizes hit exact zeros of the residual
            it.dmax   = $urandom_range(31, 0);
            it.ponded = $urandom_range(it.dmax, 0);
            it.excl   = $urandom_range(63, 0);
        end else if (kind == 5) begin
            it.dmax   = $urandom & 32'hFFFF_FFFC;
            it.ponded = '0;
            it.excl   = (it.dmax >> 2) * 3;
        end else begin
            it.dmax   = $urandom;
            it.ponded = $urandom_range(it.dmax, 0);
            if ($urandom_range(3, 0) == 0)
                it.ponded = it.dmax;
        end
        return it;
    endfunction

    // sender: bursts of random length with random gaps; drain items wait for an empty pipe
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid          <= 1'b0;
            req_if.pond_depth     <= '0;
            req_if.depression_max <= '0;
            req_if.excluded_depth <= '0;
        end else begin
            if (req_if.valid && req_if.ready)
                head_due_q.insert(head_due_q.size(), volumetric_head_of(cur_item));
            if (!req_if.valid || req_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (pend_q.size() != 0 &&
                             (!pend_q[0].drain || head_due_q.size() == 0)) begin
                    cur_item = pend_q.pop_front();
                    req_if.valid          <= 1'b1;
                    req_if.pond_depth     <= cur_item.ponded;
                    req_if.depression_max <= cur_item.dmax;
                    req_if.excluded_depth <= cur_item.excl;
                    if (burst_left == 0) begin
                        gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(25, 1);
                        burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 100)
                                                                 : $urandom_range(40, 1);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern in stretches, plus one long hold-off
    t_rx_mode    rx_mode    = RX_STEADY;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;
    int unsigned n_seen     = 0;
    t_head       due;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_seen++;
                if (head_due_q.size() == 0) begin
                    $error("tb: result item with nothing due, volumetric_head %h",
                           rsp_if.volumetric_head);
                    err_cnt++;
                end else begin
                    due = head_due_q.pop_front();
                    if (rsp_if.volumetric_head !== due.head) begin
                        $error("tb: volumetric_head expected %h, actual %h",
                               due.head, rsp_if.volumetric_head);
                        err_cnt++;
                    end
                    if (rsp_if.linear_branch !== due.lin) begin
                        $error("tb: linear_branch expected %b, actual %b",
                               due.lin, rsp_if.linear_branch);
                        err_cnt++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (!hold_done && n_seen >= 300) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                rsp_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(3, 0));
                    mode_left = $urandom_range(400, 20);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_STEADY: rsp_if.ready <= 1'b1;
                    RX_HALF:   rsp_if.ready <= $urandom_range(1, 0) == 1;
                    RX_SPARSE: rsp_if.ready <= $urandom_range(3, 0) == 0;
                    default:   rsp_if.ready <= $urandom_range(7, 0) != 0;
                endcase
            end
        end
    end

    initial begin
        t_depth_item it;

        add_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);  // zero max, bisect
        add_item(32'h0000_0001, 32'h0000_0000, 32'h0000_0005, 1'b0);  // zero max, linear
        add_item(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);  // overflow
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001, 1'b0);  // just over
        add_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);  // just fits
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_item(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        add_item(32'h0000_0000, 32'h0000_0004, 32'h0000_0003, 1'b0);  // exact zero at first midpoint
        add_item(32'h0000_0000, 32'h0400_0000, 32'h0300_0000, 1'b0);
        add_item(32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 1'b0);
        add_item(32'h0080_0000, 32'h0100_0000, 32'h0080_0000, 1'b0);
        add_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b0);
        add_item(32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        add_item(32'h0A00_0000, 32'h0A00_0000, 32'h1400_0000, 1'b0);
        add_item(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 1'b0);
        add_item(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_item(32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0);
        add_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0);
        add_item(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 1'b1);
        for (int i = 0; i < N_RANDOM; i++) begin
            it = random_depth_item();
            it.drain = (i % 500 == 250);
            pend_q.insert(pend_q.size(), it);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pend_q.size() != 0 || req_if.valid || head_due_q.size() != 0);
        repeat (SETTLE_CYCS) @(posedge i_clk);

        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/cbvh_pkg.sv
hdl/cbvh_in_if.sv
hdl/cbvh_out_if.sv
hdl/cbvh_sequencer.sv
hdl/cbvh_datapath.sv
hdl/cubic_bisection_volumetric_head.sv
tb/sv/tb.sv
